@@ design/blcd_pkg.sv @@
`default_nettype none
package blcd_pkg;

   // Configuration register indexes
   localparam logic [3:0] CSR_MIN_ON_MS    = 4'd0;
   localparam logic [3:0] CSR_MIN_OFF_MS   = 4'd1;
   localparam logic [3:0] CSR_HOLD_MS      = 4'd2;
   localparam logic [3:0] CSR_RISE_HARD_MV = 4'd3;
   localparam logic [3:0] CSR_RISE_SOFT_MV = 4'd4;
   localparam logic [3:0] CSR_FALL_HARD_MV = 4'd5;
   localparam logic [3:0] CSR_FALL_SOFT_MV = 4'd6;
   localparam logic [3:0] CSR_KEEP_DROP_MV = 4'd7;

   // Register reset values
   localparam logic [15:0] RST_MIN_ON_MS    = 16'd15000;
   localparam logic [15:0] RST_MIN_OFF_MS   = 16'd5000;
   localparam logic [23:0] RST_HOLD_MS      = 24'd180000;
   localparam logic [9:0]  RST_RISE_HARD_MV = 10'sd25;
   localparam logic [9:0]  RST_RISE_SOFT_MV = 10'sd15;
   localparam logic [9:0]  RST_FALL_HARD_MV = -10'sd70;
   localparam logic [9:0]  RST_FALL_SOFT_MV = -10'sd45;
   localparam logic [9:0]  RST_KEEP_DROP_MV = -10'sd10;

   // Voltage window and percent mapping
   localparam logic [12:0] MV_VALID_LO = 13'd2500;
   localparam logic [12:0] MV_VALID_HI = 13'd5000;
   localparam logic [12:0] MV_MAP_LO   = 13'd3300;
   localparam logic [12:0] MV_MAP_SPAN = 13'd900;
   // floor(x/9) for x <= 900 as (x * 7282) >> 16
   localparam logic [22:0] PCT_RECIP   = 23'd7282;

   // Moving average, alpha = 38/256, Q13.8
   localparam logic [29:0] EMA_KEEP    = 30'd218;
   localparam logic [29:0] EMA_NEW     = 30'd38;
   localparam logic [29:0] EMA_ROUND   = 30'd128;

   typedef struct packed {
      logic [15:0] on_time_min;
      logic [15:0] off_time_min;
      logic [23:0] hold_ms;
      logic [9:0]  rise_trip;
      logic [9:0]  rise_hint;
      logic [9:0]  fall_trip;
      logic [9:0]  fall_hint;
      logic [9:0]  sag_limit;
   } cfg_type;

   // One poll after filtering and the ring lookup
   typedef struct packed {
      logic        valid;
      logic        gauge_ok;
      logic        mv_ok;
      logic        full;
      logic [7:0]  gauge;
      logic [6:0]  map_pct;
      logic [12:0] mv;
      logic [31:0] now;
      logic [12:0] filt;
      logic [12:0] oldest;
   } poll_type;

   function automatic logic signed [13:0] sx14(input logic [9:0] v);
      return $signed({{4{v[9]}}, v});
   endfunction

   function automatic logic [7:0] bump(input logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
   endfunction

endpackage
`default_nettype wire

@@ design/blcd_ifs.sv @@
`default_nettype none
interface blcd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  gauge_percent;
   logic [12:0] cell_mv;
   logic [31:0] now_ms;
   modport source(output valid, gauge_percent, cell_mv, now_ms, input ready);
   modport sink(input valid, gauge_percent, cell_mv, now_ms, output ready);
endinterface

interface blcd_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] battery_pct;
   logic              usb_present;
   logic              redraw;
   modport source(output valid, battery_pct, usb_present, redraw, input ready);
   modport sink(input valid, battery_pct, usb_present, redraw, output ready);
endinterface

interface blcd_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [23:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/blcd_front.sv @@
`default_nettype none
module blcd_front #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   blcd_req_if.sink               req,
   input  wire logic              pop,
   output blcd_pkg::poll_type     poll
);
   import blcd_pkg::*;

   localparam int POS_W = $clog2(HISTORY_DEPTH);
   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

   logic [20:0]      ema_ff, ema_in, ema_base;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [29:0]      ema_sum;
   logic [21:0]      filt_sum;
   logic [12:0]      filt, map_x;
   logic [9:0]       map_c;
   logic [22:0]      map_prod;
   logic             mv_ok, gauge_ok, accept;
   logic             valid_ff;
   poll_type         poll_ff, poll_in;
   logic [12:0]      hist_mem [HISTORY_DEPTH];
   logic [12:0]      oldest_ff;

   assign req.ready = !valid_ff || pop;
   assign accept    = req.valid && req.ready;

   always_comb begin
      mv_ok    = (req.cell_mv >= MV_VALID_LO) && (req.cell_mv <= MV_VALID_HI);
      gauge_ok = req.gauge_percent inside {[8'd1:8'd100]};

      ema_base = (ema_ff == '0) ? {req.cell_mv, 8'd0} : ema_ff;
      ema_sum  = 30'(ema_base) * EMA_KEEP + 30'({req.cell_mv, 8'd0}) * EMA_NEW + EMA_ROUND;
      ema_in   = ema_sum[28:8];
      filt_sum = {1'b0, ema_in} + 22'd128;
      filt     = filt_sum[20:8];

      pos_in = (pos_ff == POS_W'(HISTORY_DEPTH - 1)) ? '0 : pos_ff + 1'b1;
      cnt_in = (cnt_ff == CNT_W'(HISTORY_DEPTH)) ? cnt_ff : cnt_ff + 1'b1;

      map_x    = (req.cell_mv > MV_MAP_LO) ? req.cell_mv - MV_MAP_LO : '0;
      map_c    = (map_x > MV_MAP_SPAN) ? MV_MAP_SPAN[9:0] : map_x[9:0];
      map_prod = 23'(map_c) * PCT_RECIP;

      poll_in          = '0;
      poll_in.valid    = 1'b1;
      poll_in.gauge_ok = gauge_ok;
      poll_in.mv_ok    = mv_ok;
      poll_in.full     = (cnt_in == CNT_W'(HISTORY_DEPTH));
      poll_in.gauge    = req.gauge_percent;
      poll_in.map_pct  = map_prod[22:16];
      poll_in.mv       = req.cell_mv;
      poll_in.now      = req.now_ms;
      poll_in.filt     = filt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ema_ff   <= '0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (pop) begin
            valid_ff <= 1'b0;
         end
         if (accept && mv_ok) begin
            ema_ff <= ema_in;
            pos_ff <= pos_in;
            cnt_ff <= cnt_in;
         end
      end
   end

   // Ring: write newest at pos, read oldest at the slot after it
   always_ff @(posedge clock) begin
      if (accept && mv_ok) begin
         hist_mem[pos_ff] <= filt;
      end
      if (accept) begin
         oldest_ff <= hist_mem[pos_in];
         poll_ff   <= poll_in;
      end
   end

   always_comb begin
      poll        = poll_ff;
      poll.valid  = valid_ff;
      poll.oldest = oldest_ff;
   end

endmodule
`default_nettype wire

@@ design/blcd_decide.sv @@
`default_nettype none
module blcd_decide #(
   parameter int NEED_EVIDENCE = 3
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire blcd_pkg::poll_type poll,
   input  wire blcd_pkg::cfg_type  cfg,
   output logic                   pop,
   blcd_rsp_if.source             rsp
);
   import blcd_pkg::*;

   localparam logic [7:0] NEED = 8'(NEED_EVIDENCE);

   logic              usb_ff, usb_in;
   logic [31:0]       hold_ff, hold_in;
   logic [31:0]       flip_ff, flip_in;
   logic [7:0]        rise_ff, rise_in;
   logic [7:0]        fall_ff, fall_in;
   logic signed [7:0] shown_pct_ff, pct;
   logic [12:0]       shown_mv_ff, mv_state;
   logic              shown_valid_ff;
   logic              changed, set_on, set_off;
   logic signed [13:0] delta;
   logic [31:0]       dt, hold_at;
   logic              on_long, off_short, hold_done;
   logic              out_valid_ff;
   logic signed [7:0] out_pct_ff;
   logic              out_usb_ff, out_redraw_ff;

   assign pop = poll.valid && (!out_valid_ff || rsp.ready);

   always_comb begin
      delta     = $signed({1'b0, poll.filt}) - $signed({1'b0, poll.oldest});
      dt        = poll.now - flip_ff;
      on_long   = dt >= {16'd0, cfg.on_time_min};
      off_short = dt < {16'd0, cfg.off_time_min};
      hold_done = poll.now >= hold_ff;
      hold_at   = poll.now + {8'd0, cfg.hold_ms};

      usb_in  = usb_ff;
      hold_in = hold_ff;
      flip_in = flip_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      set_on  = 1'b0;
      set_off = 1'b0;

      if (poll.mv_ok) begin
         if (poll.full) begin
            if (!usb_ff) begin
               if (off_short) begin
                  rise_in = '0;
               end else if (delta >= sx14(cfg.rise_trip)) begin
                  set_on = 1'b1;
               end else begin
                  rise_in = (delta >= sx14(cfg.rise_hint)) ? bump(rise_ff) : '0;
                  set_on  = (rise_in >= NEED);
               end
            end else if (delta > sx14(cfg.sag_limit)) begin
               hold_in = hold_at;
               fall_in = '0;
            end else if ((delta <= sx14(cfg.fall_trip)) && on_long) begin
               set_off = 1'b1;
            end else begin
               fall_in = (delta <= sx14(cfg.fall_hint)) ? bump(fall_ff) : '0;
               set_off = on_long && hold_done && (fall_in >= NEED);
            end
         end
      end else if (usb_ff && hold_done) begin
         set_off = 1'b1;
      end

      if (set_on) begin
         usb_in  = 1'b1;
         hold_in = hold_at;
         flip_in = poll.now;
         rise_in = '0;
         fall_in = '0;
      end
      if (set_off) begin
         usb_in  = 1'b0;
         flip_in = poll.now;
         rise_in = '0;
         fall_in = '0;
      end

      if (poll.gauge_ok) begin
         pct = $signed(poll.gauge);
      end else if (poll.mv_ok) begin
         pct = $signed({1'b0, poll.map_pct});
      end else if ((shown_pct_ff < 8'sd0) || (shown_pct_ff > 8'sd100)) begin
         pct = -8'sd1;
      end else begin
         pct = shown_pct_ff;
      end

      mv_state = poll.mv_ok ? poll.mv : shown_mv_ff;
      changed  = !shown_valid_ff || (pct != shown_pct_ff) || (mv_state != shown_mv_ff)
                 || (usb_in != usb_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         usb_ff         <= 1'b0;
         hold_ff        <= '0;
         flip_ff        <= '0;
         rise_ff        <= '0;
         fall_ff        <= '0;
         shown_pct_ff   <= -8'sd1;
         shown_mv_ff    <= '0;
         shown_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (pop) begin
            usb_ff       <= usb_in;
            hold_ff      <= hold_in;
            flip_ff      <= flip_in;
            rise_ff      <= rise_in;
            fall_ff      <= fall_in;
            out_valid_ff <= 1'b1;
            if (changed) begin
               shown_pct_ff   <= pct;
               shown_mv_ff    <= mv_state;
               shown_valid_ff <= 1'b1;
            end
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_pct_ff    <= changed ? pct : shown_pct_ff;
         out_usb_ff    <= usb_in;
         out_redraw_ff <= changed;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.battery_pct = out_pct_ff;
   assign rsp.usb_present = out_usb_ff;
   assign rsp.redraw      = out_redraw_ff;

endmodule
`default_nettype wire

@@ design/battery_level_and_charger_detect.sv @@
// An accepted transaction is registered in the decision stage and then in the output
// register that drives rsp. Throughput: one poll per cycle while rsp is not stalled;
// the filter, the ring write and the read of the oldest ring entry all happen in the
// accept cycle, in a single-port-write ring memory.
// A stalled result holds one poll in the decision stage and one in the output register.
// Reset (synchronous, active high) clears filter, ring pointers, USB state and registers.
`default_nettype none
module battery_level_and_charger_detect #(
   parameter int HISTORY_DEPTH = 10,
   parameter int NEED_EVIDENCE = 3
) (
   input  wire logic  clock,
   input  wire logic  reset,
   blcd_req_if.sink   req_ch,
   blcd_rsp_if.source rsp_ch,
   blcd_csr_if.sink   csr_ch
);
   import blcd_pkg::*;

   cfg_type  cfg_ff;
   poll_type poll;
   logic     pop;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.on_time_min  <= RST_MIN_ON_MS;
         cfg_ff.off_time_min <= RST_MIN_OFF_MS;
         cfg_ff.hold_ms      <= RST_HOLD_MS;
         cfg_ff.rise_trip    <= RST_RISE_HARD_MV;
         cfg_ff.rise_hint    <= RST_RISE_SOFT_MV;
         cfg_ff.fall_trip    <= RST_FALL_HARD_MV;
         cfg_ff.fall_hint    <= RST_FALL_SOFT_MV;
         cfg_ff.sag_limit    <= RST_KEEP_DROP_MV;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_MIN_ON_MS:    cfg_ff.on_time_min  <= csr_ch.data[15:0];
            CSR_MIN_OFF_MS:   cfg_ff.off_time_min <= csr_ch.data[15:0];
            CSR_HOLD_MS:      cfg_ff.hold_ms      <= csr_ch.data;
            CSR_RISE_HARD_MV: cfg_ff.rise_trip    <= csr_ch.data[9:0];
            CSR_RISE_SOFT_MV: cfg_ff.rise_hint    <= csr_ch.data[9:0];
            CSR_FALL_HARD_MV: cfg_ff.fall_trip    <= csr_ch.data[9:0];
            CSR_FALL_SOFT_MV: cfg_ff.fall_hint    <= csr_ch.data[9:0];
            CSR_KEEP_DROP_MV: cfg_ff.sag_limit    <= csr_ch.data[9:0];
            default: ;
         endcase
      end
   end

   blcd_front #(
      .HISTORY_DEPTH(HISTORY_DEPTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .pop(pop),
      .poll(poll)
   );

   blcd_decide #(
      .NEED_EVIDENCE(NEED_EVIDENCE)
   ) u_decide (
      .clock(clock),
      .reset(reset),
      .poll(poll),
      .cfg(cfg_ff),
      .pop(pop),
      .rsp(rsp_ch)
   );

   // accepted transaction lands in the decision stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> poll.valid)
      else $error("accepted poll missing from decision stage");

   // a blocked decision stage keeps its poll
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      poll.valid && !pop |=> poll.valid && $stable(poll.now) && $stable(poll.filt))
      else $error("decision stage changed while blocked");

   // with nothing pending, a taken result empties the output
   a_out_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !poll.valid |=> !rsp_ch.valid)
      else $error("result repeated");

   // a decision is taken only into a free or draining output
   a_pop_room: assert property (@(posedge clock) disable iff (reset)
      pop |-> !rsp_ch.valid || rsp_ch.ready)
      else $error("result overwritten");

endmodule
`default_nettype wire

@@ verif/blcd_status_monitor.sv @@
`timescale 1ns / 100ps
module blcd_status_monitor (
   input  logic clock,
   input  logic reset,
   blcd_req_if  req_ch,
   blcd_rsp_if  rsp_ch,
   blcd_csr_if  csr_ch,
   output int   failures,
   output int   outstanding
);
   import blcd_pkg::*;

   localparam int RING_DEPTH    = 10;
   localparam int NEED_EVIDENCE = 3;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic signed [7:0] pct;
      logic              usb;
      logic              redraw;
   } status_type;

   status_type pending_status[$];

   // register copies
   logic [15:0]       on_time_min, off_time_min;
   logic [23:0]       hold_ms;
   logic signed [9:0] rise_trip, rise_hint, fall_trip, fall_hint, sag_limit;

   // detector state
   logic [31:0] ema;
   logic [12:0] ring [RING_DEPTH];
   int          ring_fill, ring_pos;
   logic        usb_on;
   logic [31:0] hold_until, last_flip;
   logic [7:0]  rise_ev, fall_ev;
   int          shown_pct;
   logic [12:0] shown_mv;
   logic        shown_valid;

   int err_count = 0;
   int reported  = 0;

   task automatic clear_state;
      on_time_min  = RST_MIN_ON_MS;
      off_time_min = RST_MIN_OFF_MS;
      hold_ms      = RST_HOLD_MS;
      rise_trip    = RST_RISE_HARD_MV;
      rise_hint    = RST_RISE_SOFT_MV;
      fall_trip    = RST_FALL_HARD_MV;
      fall_hint    = RST_FALL_SOFT_MV;
      sag_limit    = RST_KEEP_DROP_MV;
      ema = '0;
      for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
      ring_fill   = 0;
      ring_pos    = 0;
      usb_on      = 1'b0;
      hold_until  = '0;
      last_flip   = '0;
      rise_ev     = '0;
      fall_ev     = '0;
      shown_pct   = -1;
      shown_mv    = '0;
      shown_valid = 1'b0;
   endtask

   task automatic load_register(input logic [3:0] idx, input logic [23:0] value);
      case (idx)
         CSR_MIN_ON_MS:    on_time_min  = value[15:0];
         CSR_MIN_OFF_MS:   off_time_min = value[15:0];
         CSR_HOLD_MS:      hold_ms      = value;
         CSR_RISE_HARD_MV: rise_trip    = value[9:0];
         CSR_RISE_SOFT_MV: rise_hint    = value[9:0];
         CSR_FALL_HARD_MV: fall_trip    = value[9:0];
         CSR_FALL_SOFT_MV: fall_hint    = value[9:0];
         CSR_KEEP_DROP_MV: sag_limit    = value[9:0];
         default: ;
      endcase
   endtask

   task automatic flip_usb(input logic on, input logic [31:0] now);
      usb_on = on;
      if (on) hold_until = now + {8'd0, hold_ms};
      last_flip = now;
      rise_ev   = '0;
      fall_ev   = '0;
   endtask

   task automatic compute_status(input logic [7:0] gauge, input logic [12:0] mv,
                                 input logic [31:0] now, output status_type st);
      logic        mv_ok, old_usb, changed, on_long;
      int          pct, delta;
      logic [31:0] mv32, filt, elapsed;
      logic [12:0] mv_seen;
      mv_ok   = mv >= MV_VALID_LO && mv <= MV_VALID_HI;
      old_usb = usb_on;
      mv32    = {19'd0, mv};
      elapsed = now - last_flip;

      if (gauge >= 8'd1 && gauge <= 8'd100) begin
         pct = int'(gauge);
      end else if (mv_ok) begin
         pct = (mv <= MV_MAP_LO) ? 0 :
               (int'(mv) - int'(MV_MAP_LO)) * 100 / int'(MV_MAP_SPAN);
         if (pct > 100) pct = 100;
      end else begin
         pct = shown_pct;
         if (pct < 0 || pct > 100) pct = -1;
      end

      if (mv_ok) begin
         if (ema == 0) ema = mv32 << 8;
         ema  = (ema * 32'd218 + (mv32 << 8) * 32'd38 + 32'd128) >> 8;
         filt = (ema + 32'd128) >> 8;
         ring[ring_pos] = filt[12:0];
         ring_pos = (ring_pos + 1) % RING_DEPTH;
         if (ring_fill < RING_DEPTH) ring_fill++;
         if (ring_fill >= RING_DEPTH) begin
            // ring_pos now points at the oldest sample
            delta = int'(filt) - int'(ring[ring_pos]);
            if (!usb_on) begin
               if (elapsed < {16'd0, off_time_min}) begin
                  rise_ev = '0;
               end else if (delta >= rise_trip) begin
                  flip_usb(1'b1, now);
               end else begin
                  if (delta >= rise_hint)
                     rise_ev = (rise_ev == 8'hFF) ? 8'hFF : rise_ev + 8'd1;
                  else
                     rise_ev = '0;
                  if (rise_ev >= NEED_EVIDENCE) flip_usb(1'b1, now);
               end
            end else if (delta > sag_limit) begin
               hold_until = now + {8'd0, hold_ms};
               fall_ev    = '0;
            end else begin
               on_long = elapsed >= {16'd0, on_time_min};
               if (delta <= fall_trip && on_long) begin
                  flip_usb(1'b0, now);
               end else begin
                  if (delta <= fall_hint)
                     fall_ev = (fall_ev == 8'hFF) ? 8'hFF : fall_ev + 8'd1;
                  else
                     fall_ev = '0;
                  if (on_long && now >= hold_until && fall_ev >= NEED_EVIDENCE)
                     flip_usb(1'b0, now);
               end
            end
         end
      end else if (usb_on && now >= hold_until) begin
         flip_usb(1'b0, now);
      end

      mv_seen = mv_ok ? mv : shown_mv;
      changed = !shown_valid || pct != shown_pct || mv_seen != shown_mv || usb_on != old_usb;
      if (changed) begin
         shown_pct   = pct;
         shown_mv    = mv_seen;
         shown_valid = 1'b1;
      end
      st.pct    = shown_pct[7:0];
      st.usb    = usb_on;
      st.redraw = changed;
   endtask

   always @(posedge clock) begin : watch
      status_type want, seen;
      if (reset) begin
         clear_state();
         pending_status.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) load_register(csr_ch.index, csr_ch.data);
         // a result is never taken at its own poll's edge, so compare before queuing this edge's poll
         if (rsp_ch.valid && rsp_ch.ready) begin
            seen.pct    = rsp_ch.battery_pct;
            seen.usb    = rsp_ch.usb_present;
            seen.redraw = rsp_ch.redraw;
            if (pending_status.size() == 0) begin
               err_count++;
               if (reported < MAX_REPORTS) begin
                  reported++;
                  $display("%0t: unexpected result pct %0d usb %0b redraw %0b",
                           $time, seen.pct, seen.usb, seen.redraw);
               end
            end else begin
               want = pending_status.pop_front();
               if (want !== seen) begin
                  err_count++;
                  if (reported < MAX_REPORTS) begin
                     reported++;
                     $display("%0t: exp %0d/%0b/%0b got %0d/%0b/%0b (pct/usb/redraw)",
                              $time, want.pct, want.usb, want.redraw,
                              seen.pct, seen.usb, seen.redraw);
                  end
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            compute_status(req_ch.gauge_percent, req_ch.cell_mv, req_ch.now_ms, want);
            pending_status.push_back(want);
         end
      end
      failures    <= err_count;
      outstanding <= pending_status.size();
   end

endmodule

@@ verif/battery_level_and_charger_detect_tb.sv @@
`timescale 1ns / 100ps
module battery_level_and_charger_detect_tb;
   import blcd_pkg::*;

   localparam int         CYCLE_LIMIT   = 500000;
   localparam int         TAIL_CYCLES   = 8;
   localparam int         PHASE_ITEMS   = 155;
   localparam logic [3:0] CSR_UNUSED    = 4'd15;

   typedef enum int {IDLE_RANDOM, IDLE_NONE, IDLE_SPARSE} idle_mode_type;
   typedef enum int {SET_KEEP, SET_LOOSE, SET_MILD, SET_TIGHT, SET_RAW, SET_DEFAULT} setting_type;

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   cycle_count = 0;

   idle_mode_type req_idle_mode = IDLE_RANDOM;
   idle_mode_type rsp_idle_mode = IDLE_RANDOM;

   // voltage trace generator state
   int          cur_mv   = 4200;
   int          trend    = 0;
   int          noise    = 0;
   int          seg_left = 0;
   int          step_lo  = 900;
   int          step_hi  = 1100;
   logic [31:0] now_t    = 32'd25000;

   setting_type plan [7] = '{SET_KEEP, SET_LOOSE, SET_MILD, SET_TIGHT, SET_RAW, SET_MILD,
                             SET_DEFAULT};

   blcd_req_if req_ch();
   blcd_rsp_if rsp_ch();
   blcd_csr_if csr_ch();

   battery_level_and_charger_detect dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   blcd_status_monitor status_mon (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_ch      (csr_ch),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic int draw_gap(idle_mode_type mode);
      case (mode)
         IDLE_RANDOM: return $urandom_range(0, 15);
         IDLE_NONE:   return 0;
         default:     return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
      endcase
   endfunction

   function automatic logic [23:0] mv_field(int v);
      return {14'd0, v[9:0]};
   endfunction

   // result side: stall a random number of cycles before each transaction
   initial begin : rsp_pacing
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         gap = draw_gap(rsp_idle_mode);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   task automatic send_poll(input logic [7:0] gauge, input logic [12:0] mv,
                            input logic [31:0] now);
      int gap;
      gap = draw_gap(req_idle_mode);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.gauge_percent <= gauge;
      req_ch.cell_mv       <= mv;
      req_ch.now_ms        <= now;
      req_ch.valid         <= 1'b1;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
   endtask

   // leaves valid high; the caller lowers it after the last write
   task automatic write_reg(input logic [3:0] idx, input logic [23:0] value);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
   endtask

   task automatic settle;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_setting(input setting_type kind);
      case (kind)
         SET_LOOSE: begin
            write_reg(CSR_MIN_ON_MS, 24'd0);
            write_reg(CSR_MIN_OFF_MS, 24'd0);
            write_reg(CSR_HOLD_MS, 24'd0);
            write_reg(CSR_RISE_HARD_MV, mv_field(511));
            write_reg(CSR_RISE_SOFT_MV, mv_field(-512));
            write_reg(CSR_FALL_HARD_MV, mv_field(-512));
            write_reg(CSR_FALL_SOFT_MV, mv_field(511));
            write_reg(CSR_KEEP_DROP_MV, mv_field(511));
         end
         SET_TIGHT: begin
            write_reg(CSR_MIN_ON_MS, 24'h00FFFF);
            write_reg(CSR_MIN_OFF_MS, 24'h00FFFF);
            write_reg(CSR_HOLD_MS, 24'hFFFFFF);
            write_reg(CSR_RISE_HARD_MV, mv_field(-512));
            write_reg(CSR_RISE_SOFT_MV, mv_field(511));
            write_reg(CSR_FALL_HARD_MV, mv_field(511));
            write_reg(CSR_FALL_SOFT_MV, mv_field(-512));
            write_reg(CSR_KEEP_DROP_MV, mv_field(-512));
         end
         SET_MILD: begin
            write_reg(CSR_MIN_ON_MS, 24'($urandom_range(0, 20000)));
            write_reg(CSR_MIN_OFF_MS, 24'($urandom_range(0, 10000)));
            write_reg(CSR_HOLD_MS, 24'($urandom_range(0, 60000)));
            write_reg(CSR_RISE_HARD_MV, mv_field(int'($urandom_range(5, 40))));
            write_reg(CSR_RISE_SOFT_MV, mv_field(int'($urandom_range(0, 20))));
            write_reg(CSR_FALL_HARD_MV, mv_field(-int'($urandom_range(20, 90))));
            write_reg(CSR_FALL_SOFT_MV, mv_field(-int'($urandom_range(5, 50))));
            write_reg(CSR_KEEP_DROP_MV, mv_field(-int'($urandom_range(0, 20))));
         end
         SET_RAW: begin
            // full-width data, upper bits of narrow registers must be dropped
            write_reg(CSR_MIN_ON_MS, 24'($urandom()));
            write_reg(CSR_MIN_OFF_MS, 24'($urandom()));
            write_reg(CSR_HOLD_MS, 24'($urandom()));
            write_reg(CSR_RISE_HARD_MV, 24'($urandom()));
            write_reg(CSR_RISE_SOFT_MV, 24'($urandom()));
            write_reg(CSR_FALL_HARD_MV, 24'($urandom()));
            write_reg(CSR_FALL_SOFT_MV, 24'($urandom()));
            write_reg(CSR_KEEP_DROP_MV, 24'($urandom()));
            write_reg(CSR_UNUSED, 24'($urandom()));
         end
         SET_DEFAULT: begin
            write_reg(CSR_MIN_ON_MS, 24'(RST_MIN_ON_MS));
            write_reg(CSR_MIN_OFF_MS, 24'(RST_MIN_OFF_MS));
            write_reg(CSR_HOLD_MS, RST_HOLD_MS);
            write_reg(CSR_RISE_HARD_MV, 24'(RST_RISE_HARD_MV));
            write_reg(CSR_RISE_SOFT_MV, 24'(RST_RISE_SOFT_MV));
            write_reg(CSR_FALL_HARD_MV, 24'(RST_FALL_HARD_MV));
            write_reg(CSR_FALL_SOFT_MV, 24'(RST_FALL_SOFT_MV));
            write_reg(CSR_KEEP_DROP_MV, 24'(RST_KEEP_DROP_MV));
         end
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
   endtask

   task automatic run_directed;
      send_poll(8'd0, 13'd0, 32'd0);          // first poll, nothing known
      send_poll(8'd255, 13'd8191, 32'd1000);  // both readings bad, percent kept
      send_poll(8'd100, 13'd2499, 32'd2000);
      send_poll(8'd1, 13'd5001, 32'd3000);
      send_poll(8'd101, 13'd2500, 32'd4000);  // starts the average, maps to zero
      send_poll(8'd0, 13'd3300, 32'd5000);
      send_poll(8'd0, 13'd3309, 32'd6000);
      send_poll(8'd0, 13'd4200, 32'd7000);
      send_poll(8'd0, 13'd5000, 32'd8000);    // clamps at 100
      send_poll(8'd150, 13'd4000, 32'd9000);
      // steep charge ramp: fills the ring and asserts usb
      for (int i = 0; i < 15; i++)
         send_poll(8'd0, 13'(3700 + 40 * i), 32'(10000 + 1000 * i));
   endtask

   task automatic run_random(input int count);
      int          mv_i;
      logic [7:0]  gauge;
      for (int k = 0; k < count; k++) begin
         if (seg_left == 0) begin
            seg_left = $urandom_range(8, 60);
            trend    = int'($urandom_range(0, 24)) - 12;
            noise    = $urandom_range(0, 4);
            case ($urandom_range(0, 5))
               0:       begin step_lo = 0;    step_hi = 300;   end
               1:       begin step_lo = 1000; step_hi = 20000; end
               default: begin step_lo = 900;  step_hi = 1100;  end
            endcase
            if ($urandom_range(0, 14) == 0)
               now_t = 32'hFFFF_FFFF - 32'($urandom_range(0, 20000));
            else if ($urandom_range(0, 19) == 0)
               now_t = $urandom();
            req_idle_mode = idle_mode_type'($urandom_range(0, 2));
            rsp_idle_mode = idle_mode_type'($urandom_range(0, 2));
            if ($urandom_range(0, 9) == 0) settle();
         end
         seg_left--;
         cur_mv += trend;
         if (cur_mv > 4900) begin
            cur_mv = 4900;
            trend  = -trend;
         end else if (cur_mv < 2600) begin
            cur_mv = 2600;
            trend  = -trend;
         end
         mv_i = cur_mv + int'($urandom_range(0, 2 * noise)) - noise;
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 3))
               0:       mv_i = $urandom_range(0, 2499);
               1:       mv_i = $urandom_range(5001, 8191);
               2:       mv_i = 0;
               default: mv_i = 8191;
            endcase
         end
         case ($urandom_range(0, 3))
            0:       gauge = 8'd0;
            1:       gauge = 8'($urandom_range(101, 255));
            default: gauge = 8'($urandom_range(1, 100));
         endcase
         now_t += 32'($urandom_range(step_lo, step_hi));
         send_poll(gauge, mv_i[12:0], now_t);
      end
   endtask

   initial begin
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.gauge_percent <= '0;
      req_ch.cell_mv       <= '0;
      req_ch.now_ms        <= '0;
      csr_ch.valid         <= 1'b0;
      csr_ch.index         <= '0;
      csr_ch.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      settle();
      foreach (plan[p]) begin
         apply_setting(plan[p]);
         run_random(PHASE_ITEMS);
         settle();
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (failures == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
